// ----- src/mcspg_pkg.sv -----
// Shared types and constants for the multi-channel servo pulse generator.
package mcspg_pkg;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_ANGLE = 2'd1,
    OP_LOAD_CAL  = 2'd2,
    OP_KEEPALIVE = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic REG_FRAME_LENGTH = 1'b0;
  localparam logic REG_LINK_TIMEOUT = 1'b1;

  localparam logic [15:0] FRAME_LENGTH_RST = 16'd2200;
  localparam logic [7:0]  LINK_TIMEOUT_RST = 8'd120;

  localparam int LINES_W = 15;

  // Width clamp and angle span
  localparam int          DEG_SPAN  = 180;
  localparam logic [10:0] WIDTH_MAX = 11'd2047;

  // x / 180 == (x * RECIP_K) >> RECIP_SHIFT for x < 381300
  localparam int          RECIP_SHIFT = 26;
  localparam logic [18:0] RECIP_K     = 19'(((64'd1 << RECIP_SHIFT) + DEG_SPAN - 1) / DEG_SPAN);

  typedef struct packed {
    op_t               op;
    logic [3:0]        channel;
    logic [7:0]        degrees;
    logic signed [10:0] cal_offset;
    logic signed [10:0] cal_gain;
  } item_t;

  typedef struct packed {
    logic [LINES_W-1:0] pulse_lines;
    logic               frame_start;
    logic               servo_power;
    logic               link_lost;
  } result_t;

endpackage

// ----- src/mcspg_width_calc.sv -----
// Pulse width from offset and scaled angle product: divide by 180, add, clamp.
module mcspg_width_calc (
  input  logic signed [19:0] prod,
  input  logic signed [10:0] offset,
  output logic [10:0]        width
);

  logic [18:0]        mag;
  logic [37:0]        scaled;
  logic [11:0]        q_mag;
  logic signed [12:0] q;
  logic signed [12:0] sum;

  always_comb begin
    // work on magnitude so the quotient truncates toward zero
    mag    = prod[19] ? 19'(-prod) : prod[18:0];
    scaled = 38'(mag) * 38'(mcspg_pkg::RECIP_K);
    q_mag  = scaled[mcspg_pkg::RECIP_SHIFT +: 12];
    q      = prod[19] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    sum    = 13'(offset) + q;
    if (sum < 0) begin
      width = 11'd0;
    end else if (sum > $signed({2'b00, mcspg_pkg::WIDTH_MAX})) begin
      width = mcspg_pkg::WIDTH_MAX;
    end else begin
      width = sum[10:0];
    end
  end

endmodule

// ----- src/multi_channel_servo_pulse_generator.sv -----
// Top level: servo frame counter, per-channel widths, power watchdog, result queue.
// A transaction passes the input register, the stage B register and the result queue before it shows on the output.
// Throughput: one transaction per cycle; the input register, the width/pulse
//   stage and a two-entry result queue run in lockstep and stall together
//   only when the queue is full.
// Reset (rst, synchronous): clears widths, calibration, frame counter, silent
//   frame count, power, held lines and the queue; registers return to defaults.
module multi_channel_servo_pulse_generator #(
  parameter int CHANNELS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [15:0]                  cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [3:0]                   channel,
  input  logic [7:0]                   degrees,
  input  logic signed [10:0]           cal_offset,
  input  logic signed [10:0]           cal_gain,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mcspg_pkg::LINES_W-1:0] pulse_lines,
  output logic                         frame_start,
  output logic                         servo_power,
  output logic                         link_lost
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers
  logic [15:0] frame_length;
  logic [7:0]  link_timeout;

  // Channel state
  logic [10:0]        pulse_width  [CHANNELS];
  logic signed [10:0] width_offset [CHANNELS];
  logic signed [10:0] width_gain   [CHANNELS];
  logic [15:0]        frame_counter;
  logic [7:0]         silent_frames;
  logic               power_on;
  logic [mcspg_pkg::LINES_W-1:0] held_lines;

  // Pipeline
  logic               adv;
  logic               a_valid;
  mcspg_pkg::item_t   a_item;
  logic [IDX_W-1:0]   a_idx;
  logic               a_ch_ok;
  logic signed [19:0] a_prod;

  logic               b_valid;
  mcspg_pkg::op_t     b_op;
  logic [IDX_W-1:0]   b_idx;
  logic               b_ch_ok;
  logic signed [19:0] b_prod;
  logic signed [10:0] b_offset;
  logic [10:0]        b_width;

  // Result queue
  mcspg_pkg::result_t q_mem [2];
  logic               q_wr_ptr;
  logic               q_rd_ptr;
  logic [1:0]         q_count;
  logic               q_push;
  logic               q_pop;
  mcspg_pkg::result_t res;

  // Tick evaluation
  logic [mcspg_pkg::LINES_W-1:0] lines;
  logic [16:0]        counter_inc;
  logic               is_start;
  logic               timed_out;

  // Whole pipeline moves when the queue has room: no path from out_ready to in_ready.
  assign adv      = (q_count != 2'd2);
  assign in_ready = adv;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= mcspg_pkg::FRAME_LENGTH_RST;
      link_timeout <= mcspg_pkg::LINK_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcspg_pkg::REG_FRAME_LENGTH: frame_length <= cfg_data;
        mcspg_pkg::REG_LINK_TIMEOUT: link_timeout <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: input register, calibration write, angle * gain product
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item.op         <= mcspg_pkg::op_t'(op);
      a_item.channel    <= channel;
      a_item.degrees    <= degrees;
      a_item.cal_offset <= cal_offset;
      a_item.cal_gain   <= cal_gain;
    end
  end

  assign a_idx   = IDX_W'(a_item.channel);
  assign a_ch_ok = ({2'b00, a_item.channel} < 6'(CHANNELS));
  // degrees is unsigned: prepend a zero so the product stays signed
  assign a_prod  = $signed({1'b0, a_item.degrees}) * width_gain[a_idx];

  // Calibration lands at the end of stage A, so a set-angle right behind sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        width_offset[i] <= '0;
        width_gain[i]   <= '0;
      end
    end else if (adv && a_valid && a_ch_ok && (a_item.op == mcspg_pkg::OP_LOAD_CAL)) begin
      width_offset[a_idx] <= a_item.cal_offset;
      width_gain[a_idx]   <= a_item.cal_gain;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: width update, tick evaluation, power watchdog
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op     <= a_item.op;
      b_idx    <= a_idx;
      b_ch_ok  <= a_ch_ok;
      b_prod   <= a_prod;
      b_offset <= width_offset[a_idx];
    end
  end

  mcspg_width_calc u_width_calc (
    .prod   (b_prod),
    .offset (b_offset),
    .width  (b_width)
  );

  // Each line is high while the counter is below its channel's width.
  for (genvar g = 0; g < mcspg_pkg::LINES_W; g++) begin : g_line
    if (g < CHANNELS) begin : g_used
      assign lines[g] = ({5'd0, pulse_width[g]} > frame_counter);
    end else begin : g_unused
      assign lines[g] = 1'b0;
    end
  end

  assign counter_inc = {1'b0, frame_counter} + 17'd1;
  assign is_start    = (frame_counter == 16'd0);
  assign timed_out   = (silent_frames >= link_timeout);

  always_comb begin
    res.pulse_lines = held_lines;
    res.frame_start = 1'b0;
    res.servo_power = power_on;
    res.link_lost   = 1'b0;
    unique case (b_op)
      mcspg_pkg::OP_TICK: begin
        res.pulse_lines = lines;
        res.frame_start = is_start;
        if (is_start && timed_out) begin
          res.servo_power = 1'b0;
          res.link_lost   = 1'b1;
        end
      end
      mcspg_pkg::OP_KEEPALIVE: begin
        res.servo_power = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pulse_width[i] <= '0;
      end
      frame_counter <= '0;
      silent_frames <= '0;
      power_on      <= 1'b0;
      held_lines    <= '0;
    end else if (adv && b_valid) begin
      unique case (b_op)
        mcspg_pkg::OP_TICK: begin
          held_lines <= lines;
          if (is_start) begin
            if (timed_out) begin
              // drop power and restart the silent-frame count
              power_on      <= 1'b0;
              silent_frames <= '0;
            end else begin
              silent_frames <= silent_frames + 8'd1;
            end
          end
          // wrap once the next count reaches the frame length
          frame_counter <= (counter_inc >= {1'b0, frame_length}) ? 16'd0
                                                                  : counter_inc[15:0];
        end
        mcspg_pkg::OP_SET_ANGLE: begin
          if (b_ch_ok) begin
            pulse_width[b_idx] <= b_width;
          end
        end
        mcspg_pkg::OP_KEEPALIVE: begin
          power_on      <= 1'b1;
          silent_frames <= '0;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: two entries, so a waiting result never stalls the next item
  // ---------------------------------------------------------------------------
  assign q_push = adv && b_valid;
  assign q_pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= 1'b0;
      q_rd_ptr <= 1'b0;
      q_count  <= 2'd0;
    end else begin
      if (q_push) begin
        q_wr_ptr <= ~q_wr_ptr;
      end
      if (q_pop) begin
        q_rd_ptr <= ~q_rd_ptr;
      end
      q_count <= q_count + 2'(q_push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr_ptr] <= res;
    end
  end

  assign out_valid   = (q_count != 2'd0);
  assign pulse_lines = q_mem[q_rd_ptr].pulse_lines;
  assign frame_start = q_mem[q_rd_ptr].frame_start;
  assign servo_power = q_mem[q_rd_ptr].servo_power;
  assign link_lost   = q_mem[q_rd_ptr].link_lost;

endmodule

// ----- src/mcspg_checker.sv -----
// Port-level checks for the servo pulse generator, bound to the top level.
module mcspg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mcspg_pkg::LINES_W-1:0] pulse_lines,
  input logic                          frame_start,
  input logic                          servo_power,
  input logic                          link_lost
);

  // no transaction may appear right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // an empty result side always takes input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // a timeout only fires on a frame start
  a_lost_on_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && link_lost) |-> frame_start)
    else $error("link_lost without frame_start");

  // a timeout always leaves power off
  a_lost_power_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && link_lost) |-> !servo_power)
    else $error("link_lost with power still on");

  // a stalled result keeps its pulse lines and power state
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pulse_lines)
                                   && $stable(servo_power)))
    else $error("stalled result changed");

endmodule

bind multi_channel_servo_pulse_generator mcspg_checker u_mcspg_checker (.*);
